/* rtl/awsr_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the windowed autoscale range block.
// No dependencies; imported by every module of the block but the generic RAM.
package awsr_pkg;

    // Lane count: one lane per sample series
    localparam int LANES = 3;

    // Register and result widths
    localparam int CFG_W = 15;
    localparam int OUT_W = 18;
    localparam logic [CFG_W-1:0] CFG_RESET = 15'd100;

    // Saturation limits of one bound
    localparam logic signed [OUT_W-1:0] OUT_MAX = 18'sh1FFFF;
    localparam logic signed [OUT_W-1:0] OUT_MIN = -18'sh20000;

    // Padding divisor
    localparam logic [4:0] PAD_DIV = 5'd10;

    // Per-lane control, driven by the top-level sequencer
    typedef struct packed {
        logic we;     // write the new sample
        logic re;     // read one history slot
        logic acc;    // read word has landed, fold it in
        logic first;  // landed word is the first of the scan
    } awsr_lane_ctl_t;

    // Top-level sequencer states
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SCAN  = 6'b000010,
        ST_LAND  = 6'b000100,
        ST_MERGE = 6'b001000,
        ST_CALC  = 6'b010000,
        ST_HOLD  = 6'b100000
    } awsr_state_t;

endpackage

/* rtl/awsr_ram.sv */
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module awsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 36
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/awsr_lane.sv */
`timescale 1ns / 1ps
// One scan lane: ring history of one series and its running min/max tracker.
// Depends on awsr_pkg and awsr_ram.
module awsr_lane #(
    parameter int POINTS      = 36,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          aclk,
    input  awsr_pkg::awsr_lane_ctl_t      ctl,
    input  logic [$clog2(POINTS)-1:0]     waddr,
    input  logic [$clog2(POINTS)-1:0]     raddr,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    output logic signed [SAMPLE_BITS-1:0] lane_lo,
    output logic signed [SAMPLE_BITS-1:0] lane_hi
);

    import awsr_pkg::*;

    logic [SAMPLE_BITS-1:0]        rdata;
    logic signed [SAMPLE_BITS-1:0] word;
    logic signed [SAMPLE_BITS-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_BITS-1:0] hi_reg, hi_next;

    // History store
    awsr_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (POINTS)
    ) u_hist (
        .aclk  (aclk),
        .we    (ctl.we),
        .waddr (waddr),
        .wdata (sample),
        .re    (ctl.re),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign word = $signed(rdata);

    // Running min/max, restarted on the first word of a scan
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (ctl.acc) begin
            if (ctl.first) begin
                lo_next = word;
                hi_next = word;
            end else begin
                if (word < lo_reg) lo_next = word;
                if (word > hi_reg) hi_next = word;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

    assign lane_lo = lo_reg;
    assign lane_hi = hi_reg;

endmodule

/* rtl/awsr_bounds.sv */
`timescale 1ns / 1ps
// Merge stage: combines lane min/max, enforces minimum span, pads by span/10.
// Depends on awsr_pkg. Divide by ten is a reciprocal multiply split into a low and a high partial product.
module awsr_bounds #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                            aclk,
    input  logic                                            aresetn,
    input  logic                                            start,
    input  logic [awsr_pkg::CFG_W-1:0]                      min_half_span,
    input  logic [awsr_pkg::LANES-1:0][SAMPLE_BITS-1:0]     lane_lo,
    input  logic [awsr_pkg::LANES-1:0][SAMPLE_BITS-1:0]     lane_hi,
    output logic                                            done,
    output logic signed [awsr_pkg::OUT_W-1:0]               axis_low,
    output logic signed [awsr_pkg::OUT_W-1:0]               axis_high
);

    import awsr_pkg::*;

    // Working width: sample range plus span headroom, never below the result width
    localparam int AW   = (SAMPLE_BITS + 4 > OUT_W + 1) ? SAMPLE_BITS + 4 : OUT_W + 1;
    // Span magnitude bits, reciprocal shift and product width
    localparam int XW   = AW - 1;
    localparam int SH   = AW + 3;
    localparam int PW   = XW + AW;
    // Reciprocal split into a low and a high half, one partial product a cycle
    localparam int RL   = AW / 2;
    localparam int RH   = AW - RL;
    localparam int LW   = XW + RL;
    localparam int HW   = XW + RH;
    localparam int NDIV = 2;
    localparam int CW   = $clog2(NDIV + 1);
    // ceil(2^SH / 10): exact quotient for any span below 2^XW
    localparam logic [AW-1:0] RECIP =
        AW'(((64'd1 << SH) + 64'(PAD_DIV) - 64'd1) / 64'(PAD_DIV));
    localparam logic [RL-1:0] RECIP_LO = RECIP[RL-1:0];
    localparam logic [RH-1:0] RECIP_HI = RECIP[AW-1:RL];

    logic signed [SAMPLE_BITS-1:0] g_lo, g_hi;
    logic signed [SAMPLE_BITS-1:0] glo_reg, ghi_reg;
    logic                          ld_reg, busy_reg, fin_reg, done_reg;
    logic [CW-1:0]                 cnt_reg;

    logic signed [AW-1:0] lo_e, hi_e, sum_e, mid_e, span_e, mhs_e, twice_e;
    logic signed [AW-1:0] lo2_next, hi2_next, span2_next;
    logic signed [AW-1:0] lo2_reg, hi2_reg;
    logic [XW-1:0]        span_reg;
    logic [PW-1:0]        prod_reg, prod_next;
    logic [LW-1:0]        pp_lo;
    logic [HW-1:0]        pp_hi;
    logic [PW-SH-1:0]     quo;
    logic signed [AW-1:0] pad_e, low_e, high_e;
    logic signed [OUT_W-1:0] low_reg, high_reg;

    // Global extremes over the lanes
    always_comb begin
        g_lo = $signed(lane_lo[0]);
        g_hi = $signed(lane_hi[0]);
        for (int k = 1; k < LANES; k++) begin
            if ($signed(lane_lo[k]) < g_lo) g_lo = $signed(lane_lo[k]);
            if ($signed(lane_hi[k]) > g_hi) g_hi = $signed(lane_hi[k]);
        end
    end

    // Midpoint (rounded toward zero) and minimum-span enforcement
    always_comb begin
        lo_e    = {{(AW-SAMPLE_BITS){glo_reg[SAMPLE_BITS-1]}}, glo_reg};
        hi_e    = {{(AW-SAMPLE_BITS){ghi_reg[SAMPLE_BITS-1]}}, ghi_reg};
        sum_e   = lo_e + hi_e;
        mid_e   = $signed(sum_e + {{(AW-1){1'b0}}, sum_e[AW-1]}) >>> 1;
        span_e  = hi_e - lo_e;
        mhs_e   = {{(AW-CFG_W){1'b0}}, min_half_span};
        twice_e = mhs_e <<< 1;
        if (span_e < twice_e) begin
            lo2_next   = mid_e - mhs_e;
            hi2_next   = mid_e + mhs_e;
            span2_next = twice_e;
        end else begin
            lo2_next   = lo_e;
            hi2_next   = hi_e;
            span2_next = span_e;
        end
    end

    // Divide by ten: accumulate span * RECIP, low half first, then the high half
    always_comb begin
        pp_lo = LW'(span_reg) * LW'(RECIP_LO);
        pp_hi = HW'(span_reg) * HW'(RECIP_HI);
        if (cnt_reg == CW'(NDIV)) begin
            prod_next = prod_reg + PW'(pp_lo);
        end else begin
            prod_next = prod_reg + (PW'(pp_hi) << RL);
        end
        quo = prod_reg[PW-1:SH];
    end

    // Padding (at least one); saturation follows in the datapath registers
    always_comb begin
        pad_e  = (quo == '0) ? AW'(1) : AW'(quo);
        low_e  = lo2_reg - pad_e;
        high_e = hi2_reg + pad_e;
    end

    // Sequencing
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_reg   <= 1'b0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            ld_reg   <= start;
            fin_reg  <= 1'b0;
            done_reg <= fin_reg;
            if (ld_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NDIV);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (start) begin
            glo_reg <= g_lo;
            ghi_reg <= g_hi;
        end
        if (ld_reg) begin
            lo2_reg  <= lo2_next;
            hi2_reg  <= hi2_next;
            span_reg <= span2_next[XW-1:0];
            prod_reg <= '0;
        end else if (busy_reg) begin
            prod_reg <= prod_next;
        end
        if (fin_reg) begin
            if (low_e > AW'(OUT_MAX))       low_reg <= OUT_MAX;
            else if (low_e < AW'(OUT_MIN))  low_reg <= OUT_MIN;
            else                            low_reg <= low_e[OUT_W-1:0];
            if (high_e > AW'(OUT_MAX))      high_reg <= OUT_MAX;
            else if (high_e < AW'(OUT_MIN)) high_reg <= OUT_MIN;
            else                            high_reg <= high_e[OUT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign axis_low  = low_reg;
    assign axis_high = high_reg;

endmodule

/* rtl/windowed_autoscale_range.sv */
`timescale 1ns / 1ps
// Windowed autoscale range: three history lanes scanned side by side, then merged.
// A word is taken in ST_IDLE, then its window is scanned (up to 36 slots at defaults,
// one read per cycle per lane RAM), merged and padded, and the result is held until
// the output register is free; s_tready stays low from acceptance until then, and the
// next word is taken while a result waits.
// Reset (aresetn, synchronous, active low) empties the window and sets min_half_span to 100.
module windowed_autoscale_range #(
    parameter int POINTS      = 36,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // sample_x, sample_y, sample_z from bit 0 up, zero filled to bytes
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // axis_low [17:0], axis_high [35:18], zero filled to bytes
    output logic [39:0]                           m_tdata,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // min_half_span
    input  logic [awsr_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready
);

    import awsr_pkg::*;

    localparam int IW = $clog2(POINTS);
    localparam int FW = $clog2(POINTS + 1);

    awsr_state_t          state_reg, state_next;
    logic [IW-1:0]        wslot_reg;
    logic [FW-1:0]        filled_reg;
    logic [IW-1:0]        raddr_reg;
    logic                 acc_reg, first_reg;
    logic [CFG_W-1:0]     mhs_reg;
    logic                 m_tvalid_reg;
    logic [39:0]          m_tdata_reg;

    logic                 s_take, scan_last, start, done, out_load;
    awsr_lane_ctl_t       ctl;
    logic [LANES-1:0][SAMPLE_BITS-1:0] lane_lo, lane_hi;
    logic signed [OUT_W-1:0] axis_low, axis_high;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_take    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign scan_last = (FW'(raddr_reg) + FW'(1)) == filled_reg;
    assign start     = (state_reg == ST_MERGE);
    assign out_load  = (state_reg == ST_HOLD) && (!m_tvalid_reg || m_tready);

    // Lane control
    always_comb begin
        ctl.we    = s_take;
        ctl.re    = (state_reg == ST_SCAN);
        ctl.acc   = acc_reg;
        ctl.first = first_reg;
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_take) state_next = ST_SCAN;
            ST_SCAN:  if (scan_last) state_next = ST_LAND;
            ST_LAND:  state_next = ST_MERGE;
            ST_MERGE: state_next = ST_CALC;
            ST_CALC:  if (done) state_next = ST_HOLD;
            ST_HOLD:  if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wslot_reg    <= '0;
            filled_reg   <= '0;
            raddr_reg    <= '0;
            acc_reg      <= 1'b0;
            first_reg    <= 1'b0;
            mhs_reg      <= CFG_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= ctl.re;
            first_reg <= ctl.re && (raddr_reg == '0);
            if (cfg_valid && cfg_ready) begin
                mhs_reg <= cfg_data;
            end
            // Ring write pointer and fill count
            if (s_take) begin
                wslot_reg <= (wslot_reg == IW'(POINTS - 1)) ? '0 : wslot_reg + 1'b1;
                if (filled_reg != FW'(POINTS)) filled_reg <= filled_reg + 1'b1;
                raddr_reg <= '0;
            end else if (ctl.re && !scan_last) begin
                raddr_reg <= raddr_reg + 1'b1;
            end
            // Output register
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {4'b0000, axis_high, axis_low};
        end
    end

    // One lane per series
    for (genvar k = 0; k < LANES; k++) begin : g_lane
        awsr_lane #(
            .POINTS      (POINTS),
            .SAMPLE_BITS (SAMPLE_BITS)
        ) u_lane (
            .aclk    (aclk),
            .ctl     (ctl),
            .waddr   (wslot_reg),
            .raddr   (raddr_reg),
            .sample  ($signed(s_tdata[k*SAMPLE_BITS +: SAMPLE_BITS])),
            .lane_lo (lane_lo[k]),
            .lane_hi (lane_hi[k])
        );
    end

    awsr_bounds #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_bounds (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (start),
        .min_half_span (mhs_reg),
        .lane_lo       (lane_lo),
        .lane_hi       (lane_hi),
        .done          (done),
        .axis_low      (axis_low),
        .axis_high     (axis_high)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        filled_reg <= FW'(POINTS))
        else $error("fill count beyond window depth");

    a_scan_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (FW'(raddr_reg) < filled_reg))
        else $error("scan reads an unwritten slot");

    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[17:0]) < $signed(m_tdata[35:18])))
        else $error("low bound not below high bound");

    a_done_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        done |-> (state_reg == ST_CALC))
        else $error("merge result outside calculation phase");

endmodule

/* tb/axis_range_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for windowed_autoscale_range: watches the sample, result and config channels.
// Keeps its own window and span floor, predicts each bound pair; depends on awsr_pkg.
module axis_range_checker #(
    parameter int POINTS = 36
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // sample_x [15:0], sample_y [31:16], sample_z [47:32]
    input  logic [47:0]                 s_tdata,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    // axis_low [17:0], axis_high [35:18], zero filled
    input  logic [39:0]                 m_tdata,
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [awsr_pkg::CFG_W-1:0]  cfg_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    output int                          failures,
    output int                          outstanding
);
    import awsr_pkg::*;

    localparam int PAD_DIVISOR = 10;

    typedef struct packed {
        logic signed [OUT_W-1:0] low;
        logic signed [OUT_W-1:0] high;
    } axis_bounds_t;

    // Bound pairs still owed by the block, oldest first
    axis_bounds_t expected_bounds[$];

    // Model of the three sample histories
    logic signed [15:0] hist_x [POINTS];
    logic signed [15:0] hist_y [POINTS];
    logic signed [15:0] hist_z [POINTS];
    int                 write_pos;
    int                 filled;
    logic [CFG_W-1:0]   half_span;
    int                 fail_count = 0;

    function automatic logic signed [OUT_W-1:0] saturate_bound(input int v);
        if (v > OUT_MAX) return OUT_MAX;
        if (v < OUT_MIN) return OUT_MIN;
        return v[OUT_W-1:0];
    endfunction

    // Store one word's samples, rescan the window and work out the axis bounds
    function automatic axis_bounds_t push_and_predict(input logic signed [15:0] x,
                                                      input logic signed [15:0] y,
                                                      input logic signed [15:0] z);
        int           lo;
        int           hi;
        int           mid;
        int           pad;
        int           floor_half;
        axis_bounds_t b;
        hist_x[write_pos] = x;
        hist_y[write_pos] = y;
        hist_z[write_pos] = z;
        write_pos = (write_pos == POINTS - 1) ? 0 : write_pos + 1;
        if (filled < POINTS) filled++;

        // only written slots take part
        lo = hist_x[0];
        hi = hist_x[0];
        for (int i = 0; i < filled; i++) begin
            if (hist_x[i] < lo) lo = hist_x[i];
            if (hist_x[i] > hi) hi = hist_x[i];
            if (hist_y[i] < lo) lo = hist_y[i];
            if (hist_y[i] > hi) hi = hist_y[i];
            if (hist_z[i] < lo) lo = hist_z[i];
            if (hist_z[i] > hi) hi = hist_z[i];
        end

        // midpoint truncates toward zero; narrow spans widen about it
        mid        = (hi + lo) / 2;
        floor_half = int'(half_span);
        if (hi - lo < 2 * floor_half) begin
            lo = mid - floor_half;
            hi = mid + floor_half;
        end
        pad = (hi - lo) / PAD_DIVISOR;
        if (pad < 1) pad = 1;

        b.low  = saturate_bound(lo - pad);
        b.high = saturate_bound(hi + pad);
        return b;
    endfunction

    // Channel monitor: config first, then compare the result, then log the new word
    always @(posedge aclk) begin : monitor
        axis_bounds_t want;
        logic signed [OUT_W-1:0] got_low;
        logic signed [OUT_W-1:0] got_high;
        got_low  = m_tdata[OUT_W-1:0];
        got_high = m_tdata[2*OUT_W-1:OUT_W];
        if (!aresetn) begin
            expected_bounds.delete();
            write_pos = 0;
            filled    = 0;
            half_span = CFG_RESET;
        end else begin
            if (cfg_valid && cfg_ready) half_span = cfg_data;

            if (m_tvalid && m_tready) begin
                if (expected_bounds.size() == 0) begin
                    $error("result word with nothing pending: axis_low %0d axis_high %0d",
                           got_low, got_high);
                    fail_count++;
                end else begin
                    want = expected_bounds.pop_front();
                    if (got_low !== want.low) begin
                        $error("axis_low: expected %0d, got %0d", want.low, got_low);
                        fail_count++;
                    end
                    if (got_high !== want.high) begin
                        $error("axis_high: expected %0d, got %0d", want.high, got_high);
                        fail_count++;
                    end
                end
            end

            if (s_tvalid && s_tready)
                expected_bounds.push_back(push_and_predict(s_tdata[15:0], s_tdata[31:16],
                                                           s_tdata[47:32]));
        end
        failures    <= fail_count;
        outstanding <= expected_bounds.size();
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Top of the windowed_autoscale_range bench: clock, reset, sample and config stimulus.
// Depends on awsr_pkg, the block itself and axis_range_checker.
module tb;
    import awsr_pkg::*;

    localparam int LIMIT_CYCLES = 500000;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    // sample_x [15:0], sample_y [31:16], sample_z [47:32]
    logic [47:0]       s_tdata   = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    // axis_low [17:0], axis_high [35:18], zero filled
    logic [39:0]       m_tdata;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [CFG_W-1:0]  cfg_data  = '0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;

    int failures;
    int outstanding;
    int send_idle_pct = 35;
    int recv_idle_pct = 86;
    int cycle_count   = 0;

    windowed_autoscale_range dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    axis_range_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .m_tdata     (m_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .cfg_data    (cfg_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .failures    (failures),
        .outstanding (outstanding)
    );

    always #10 aclk = ~aclk;

    // Receiver back-pressure, one draw per cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("windowed_autoscale_range verification failed");
            $finish;
        end
    end

    // One sample word, with idle cycles drawn one at a time before it
    task automatic send_word(input logic signed [15:0] x,
                             input logic signed [15:0] y,
                             input logic signed [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tdata  <= {z, y, x};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        do @(posedge aclk); while (outstanding != 0);
    endtask

    task automatic write_half_span(input logic [CFG_W-1:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Sample near a centre, clipped to the 16-bit range
    function automatic logic signed [15:0] pick_sample(input int centre, input int spread);
        int v;
        v = centre + int'($urandom_range(2 * spread)) - spread;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    // Runs of clustered samples so the window narrows, with rare full-range noise
    task automatic run_random_phase(input int send_pct, input int recv_pct,
                                    input logic [CFG_W-1:0] span_value, input int count);
        int centre;
        int spread;
        wait_drained();
        write_half_span(span_value);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        for (int n = 0; n < count; n++) begin
            if (n % 45 == 0) begin
                centre = int'($urandom_range(65535)) - 32768;
                spread = 1 << $urandom_range(15);
            end
            if ($urandom_range(79) == 0)
                send_word(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                          16'($urandom_range(65535)));
            else
                send_word(pick_sample(centre, spread), pick_sample(centre, spread),
                          pick_sample(centre, spread));
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed words under the reset span floor: single-slot window, negative odd
        // midpoint, span exactly at the floor, then field extremes
        send_word(16'sd0, 16'sd0, 16'sd0);
        send_word(-16'sd5, -16'sd2, -16'sd3);
        send_word(16'sd7, -16'sd7, 16'sd1);
        send_word(16'sd100, -16'sd100, 16'sd0);
        send_word(-16'sd1, -16'sd1, -16'sd1);
        send_word(16'sd101, 16'sd0, 16'sd0);
        send_word(16'sh8000, 16'sh8000, 16'sh8000);
        send_word(16'sd32767, 16'sd32767, 16'sd32767);
        send_word(16'sd0, 16'sh8000, 16'sd32767);
        send_word(16'sd21845, -16'sd21846, 16'sd1);
        send_word(-16'sd1, 16'sd0, 16'sd1);
        s_tvalid <= 1'b0;

        run_random_phase(35, 86, 15'h7FFF, 130);
        run_random_phase(86, 35, 15'($urandom_range(1, 32766)), 130);
        run_random_phase(0, 0, 15'd0, 140);

        wait_drained();
        repeat (60) @(posedge aclk);
        if (failures == 0)
            $display("windowed_autoscale_range verification clean");
        else
            $display("windowed_autoscale_range verification failed");
        $finish;
    end

endmodule
